@@ sv/yuyv_to_rgba_converter_assert.svh @@
// Assertion macros used by the YUYV to RGBA converter RTL.
`ifndef YUYV_TO_RGBA_CONVERTER_ASSERT_SVH
`define YUYV_TO_RGBA_CONVERTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define Y2R_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("y2r assertion failed");

`define Y2R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("y2r assertion failed");

`else

`define Y2R_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define Y2R_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/y2r_pkg.sv @@
// Types and coefficients for the YUYV to RGBA converter.
`default_nettype none

package y2r_pkg;

    localparam int PROD_W = 21;
    localparam int SUM_W  = 22;
    localparam int FRAC_BITS = 10;
    localparam int CHAN_W = 8;

    localparam logic signed [PROD_W-1:0] GAIN_LUMA    = PROD_W'(1192);
    localparam logic signed [PROD_W-1:0] GAIN_V_RED   = PROD_W'(1634);
    localparam logic signed [PROD_W-1:0] GAIN_V_GREEN = PROD_W'(833);
    localparam logic signed [PROD_W-1:0] GAIN_U_GREEN = PROD_W'(400);
    localparam logic signed [PROD_W-1:0] GAIN_U_BLUE  = PROD_W'(2066);
    localparam logic signed [9:0] LUMA_OFFSET   = 10'sd16;
    localparam logic signed [9:0] CHROMA_OFFSET = 10'sd128;
    localparam logic [CHAN_W-1:0] CHANNEL_MAX   = 8'hff;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
    } t_yuyv;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
    } t_rgb;

    typedef struct packed {
        logic signed [PROD_W-1:0] luma0;
        logic signed [PROD_W-1:0] luma1;
        logic signed [PROD_W-1:0] v_red;
        logic signed [PROD_W-1:0] v_green;
        logic signed [PROD_W-1:0] u_green;
        logic signed [PROD_W-1:0] u_blue;
    } t_prod;

    typedef struct packed {
        logic signed [SUM_W-1:0] red0;
        logic signed [SUM_W-1:0] green0;
        logic signed [SUM_W-1:0] blue0;
        logic signed [SUM_W-1:0] red1;
        logic signed [SUM_W-1:0] green1;
        logic signed [SUM_W-1:0] blue1;
    } t_sum;

    typedef struct packed {
        logic valid;
        logic load;
    } t_stage_ctl;

endpackage

`default_nettype wire

@@ sv/yuyv_to_rgba_converter.sv @@
// Top level of the YUYV to RGB pixel-pair converter.
// An accepted transfer passes through the multiply, add and clamp registers before reaching the output.
// Throughput is one YUYV word per cycle while o_stall is low; the multiply, add and clamp stages are each registered.
// A stalled output stops only the stages behind it that hold data, so empty stages still fill.
// Synchronous reset clears the valid bit of every stage; the datapath registers are not reset.
`default_nettype none

`include "yuyv_to_rgba_converter_assert.svh"

module yuyv_to_rgba_converter
    import y2r_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_stall,
    input  t_yuyv i_data,
    output logic  o_valid,
    input  wire   i_stall,
    output t_rgb  o_data
);

    logic       s1_valid;
    logic       s2_valid;
    logic       adv1;
    logic       adv2;
    logic       adv3;
    t_prod      s1_prod;
    t_sum       s2_sum;
    t_stage_ctl ctl1;
    t_stage_ctl ctl2;
    t_stage_ctl ctl3;

    always_comb begin
        adv3 = !o_valid || !i_stall;
        adv2 = !s2_valid || adv3;
        adv1 = !s1_valid || adv2;
        ctl1 = '{valid: i_valid, load: adv1};
        ctl2 = '{valid: s1_valid, load: adv2};
        ctl3 = '{valid: s2_valid, load: adv3};
    end

    assign o_stall = !adv1;

    y2r_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl1),
        .i_data  (i_data),
        .o_valid (s1_valid),
        .o_prod  (s1_prod)
    );

    y2r_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl2),
        .i_prod  (s1_prod),
        .o_valid (s2_valid),
        .o_sum   (s2_sum)
    );

    y2r_clamp u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl3),
        .i_sum   (s2_sum),
        .o_valid (o_valid),
        .o_rgb   (o_data)
    );

    `Y2R_ASSERT_SAME(a_stall_only_when_full, i_clk, i_rst_n, o_stall, s1_valid && s2_valid && o_valid && i_stall)
    `Y2R_ASSERT_NEXT(a_accept_enters_stage1, i_clk, i_rst_n, i_valid && !o_stall, s1_valid)
    `Y2R_ASSERT_NEXT(a_stage2_drains_to_out, i_clk, i_rst_n, s2_valid && !o_valid, o_valid)

endmodule

`default_nettype wire

@@ sv/y2r_mult.sv @@
// First stage: removes the sample offsets and forms the coefficient products.
`default_nettype none

module y2r_mult
    import y2r_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_stage_ctl i_ctl,
    input  t_yuyv      i_data,
    output logic       o_valid,
    output t_prod      o_prod
);

    logic signed [9:0] s_y0;
    logic signed [9:0] s_y1;
    logic signed [9:0] s_u;
    logic signed [9:0] s_v;
    t_prod             n_prod;
    t_prod             r_prod;
    logic              r_valid;

    always_comb begin
        s_y0 = signed'({2'b00, i_data.luma_first}) - LUMA_OFFSET;
        s_y1 = signed'({2'b00, i_data.luma_second}) - LUMA_OFFSET;
        s_u  = signed'({2'b00, i_data.chroma_blue}) - CHROMA_OFFSET;
        s_v  = signed'({2'b00, i_data.chroma_red}) - CHROMA_OFFSET;
        n_prod.luma0   = PROD_W'(s_y0) * GAIN_LUMA;
        n_prod.luma1   = PROD_W'(s_y1) * GAIN_LUMA;
        n_prod.v_red   = PROD_W'(s_v) * GAIN_V_RED;
        n_prod.v_green = PROD_W'(s_v) * GAIN_V_GREEN;
        n_prod.u_green = PROD_W'(s_u) * GAIN_U_GREEN;
        n_prod.u_blue  = PROD_W'(s_u) * GAIN_U_BLUE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_ctl.valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

`default_nettype wire

@@ sv/y2r_sum.sv @@
// Second stage: adds the luma and chroma products of each channel, subtracting the chroma products for green.
`default_nettype none

module y2r_sum
    import y2r_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_stage_ctl i_ctl,
    input  t_prod      i_prod,
    output logic       o_valid,
    output t_sum       o_sum
);

    t_sum n_sum;
    t_sum r_sum;
    logic r_valid;

    always_comb begin
        n_sum.red0   = SUM_W'(i_prod.luma0) + SUM_W'(i_prod.v_red);
        n_sum.green0 = SUM_W'(i_prod.luma0) - SUM_W'(i_prod.v_green)
                       - SUM_W'(i_prod.u_green);
        n_sum.blue0  = SUM_W'(i_prod.luma0) + SUM_W'(i_prod.u_blue);
        n_sum.red1   = SUM_W'(i_prod.luma1) + SUM_W'(i_prod.v_red);
        n_sum.green1 = SUM_W'(i_prod.luma1) - SUM_W'(i_prod.v_green)
                       - SUM_W'(i_prod.u_green);
        n_sum.blue1  = SUM_W'(i_prod.luma1) + SUM_W'(i_prod.u_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_ctl.valid) begin
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;

endmodule

`default_nettype wire

@@ sv/y2r_clamp.sv @@
// Third stage: drops the fraction bits, clamps each channel and holds the output.
`default_nettype none

module y2r_clamp
    import y2r_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_stage_ctl i_ctl,
    input  t_sum       i_sum,
    output logic       o_valid,
    output t_rgb       o_rgb
);

    localparam int HIGH_LSB = FRAC_BITS + CHAN_W;

    function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] sum);
        logic [CHAN_W-1:0] res;
        if (sum[SUM_W-1]) begin
            res = '0;
        end else if (|sum[SUM_W-2:HIGH_LSB]) begin
            res = CHANNEL_MAX;
        end else begin
            res = sum[HIGH_LSB-1:FRAC_BITS];
        end
        return res;
    endfunction

    t_rgb n_rgb;
    t_rgb r_rgb;
    logic r_valid;

    always_comb begin
        n_rgb.red_first    = clamp_chan(i_sum.red0);
        n_rgb.green_first  = clamp_chan(i_sum.green0);
        n_rgb.blue_first   = clamp_chan(i_sum.blue0);
        n_rgb.red_second   = clamp_chan(i_sum.red1);
        n_rgb.green_second = clamp_chan(i_sum.green1);
        n_rgb.blue_second  = clamp_chan(i_sum.blue1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_ctl.valid) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the YUYV to RGB pixel-pair converter.
`timescale 1ns / 100ps

module tb;
    import y2r_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;

    localparam int K_LUMA    = 1192;
    localparam int K_V_RED   = 1634;
    localparam int K_V_GREEN = 833;
    localparam int K_U_GREEN = 400;
    localparam int K_U_BLUE  = 2066;
    localparam int Y_BLACK   = 16;
    localparam int C_ZERO    = 128;
    localparam int Q_SHIFT   = 10;
    localparam int PIXEL_MAX = 255;

    class rgb_scoreboard;
        t_yuyv words_q[$];
        t_rgb  rgb_q[$];
        int    mismatches;
        int    checked;
        int    accepted;

        function new();
            mismatches = 0;
            checked    = 0;
            accepted   = 0;
        endfunction

        static function logic [7:0] saturate(int sum);
            if (sum < 0) begin
                return 8'h00;
            end
            if ((sum >>> Q_SHIFT) > PIXEL_MAX) begin
                return 8'hff;
            end
            return 8'(sum >>> Q_SHIFT);
        endfunction

        static function t_rgb convert(t_yuyv w);
            int   u;
            int   v;
            int   base0;
            int   base1;
            t_rgb p;
            u     = int'(w.chroma_blue) - C_ZERO;
            v     = int'(w.chroma_red) - C_ZERO;
            base0 = K_LUMA * (int'(w.luma_first) - Y_BLACK);
            base1 = K_LUMA * (int'(w.luma_second) - Y_BLACK);
            p.red_first    = saturate(base0 + K_V_RED * v);
            p.green_first  = saturate(base0 - K_V_GREEN * v - K_U_GREEN * u);
            p.blue_first   = saturate(base0 + K_U_BLUE * u);
            p.red_second   = saturate(base1 + K_V_RED * v);
            p.green_second = saturate(base1 - K_V_GREEN * v - K_U_GREEN * u);
            p.blue_second  = saturate(base1 + K_U_BLUE * u);
            return p;
        endfunction

        function void note_word(t_yuyv w);
            words_q.push_back(w);
            rgb_q.push_back(convert(w));
            accepted++;
        endfunction

        function int pending();
            return rgb_q.size();
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_channel(string name, logic [7:0] got, logic [7:0] want, t_yuyv w);
            if (got !== want) begin
                report($sformatf("%s for word %h is %h, expected %h", name, w, got, want));
            end
        endtask

        task check_pixels(t_rgb got);
            t_yuyv w;
            t_rgb  want;
            if (rgb_q.size() == 0) begin
                report($sformatf("pixel pair %h arrived with nothing outstanding", got));
                return;
            end
            w    = words_q.pop_front();
            want = rgb_q.pop_front();
            checked++;
            check_channel("red_first", got.red_first, want.red_first, w);
            check_channel("green_first", got.green_first, want.green_first, w);
            check_channel("blue_first", got.blue_first, want.blue_first, w);
            check_channel("red_second", got.red_second, want.red_second, w);
            check_channel("green_second", got.green_second, want.green_second, w);
            check_channel("blue_second", got.blue_second, want.blue_second, w);
        endtask
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_yuyv i_data;
    logic  o_valid;
    logic  i_stall;
    t_rgb  o_data;

    rgb_scoreboard scoreboard = new();

    int   cycle_count   = 0;
    int   stalled_offers = 0;
    int   stall_level   = 0;
    int   hold_left     = 0;
    int   run_left      = 0;
    bit   stalling      = 1'b0;
    bit   hold_request  = 1'b0;

    logic [7:0] corner_bytes[10] = '{8'd0, 8'd1, 8'd16, 8'd127, 8'd128,
                                     8'd129, 8'd235, 8'd240, 8'd254, 8'd255};

    logic [31:0] directed_words[20] = '{
        32'h00000000, 32'hffffffff, 32'h10801080, 32'heb80eb80,
        32'hff800080, 32'h0080ff80, 32'h80008000, 32'h80ff80ff,
        32'h800080ff, 32'h80ff8000, 32'h1000ebff, 32'hebff1000,
        32'h515a51f0, 32'h91369122, 32'h29f0296e, 32'h117f1281,
        32'h00ffff00, 32'hff0000ff, 32'h80808080, 32'h0101fefe
    };

    yuyv_to_rgba_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid) begin
            if (o_stall) begin
                stalled_offers++;
            end else begin
                scoreboard.note_word(i_data);
            end
        end
        if (i_rst_n && o_valid && !i_stall) begin
            scoreboard.check_pixels(o_data);
        end
    end

    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (run_left == 0) begin
                stalling = !stalling && (stall_level != 0);
                if (stalling) begin
                    run_left = $urandom_range(1, (stall_level == 2) ? 6 : 2);
                end else begin
                    run_left = $urandom_range(1, (stall_level == 2) ? 3 : 8);
                end
            end
            run_left--;
            i_stall <= stalling;
        end
    end

    function automatic logic [7:0] corner_byte();
        return corner_bytes[$urandom_range(0, 9)];
    endfunction

    function automatic t_yuyv random_word();
        t_yuyv w;
        w = t_yuyv'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            w.luma_first  = corner_byte();
            w.chroma_blue = corner_byte();
            w.luma_second = corner_byte();
            w.chroma_red  = corner_byte();
        end
        return w;
    endfunction

    task automatic drive_word(input t_yuyv w);
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic run_traffic(input int count, input int max_gap);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 12);
        for (int n = 0; n < count; n++) begin
            drive_word(random_word());
            burst_left--;
            if (max_gap > 0 && burst_left <= 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, max_gap);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (scoreboard.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_words[k]) begin
            drive_word(t_yuyv'(directed_words[k]));
        end

        stall_level = 1;
        run_traffic(150, 8);

        // The output holds off while words keep coming, so the pipeline fills and stalls.
        hold_request = 1'b1;
        run_traffic(30, 0);
        pause_until_drained();

        stall_level = 0;
        run_traffic(150, 0);
        pause_until_drained();

        stall_level = 2;
        run_traffic(200, 10);
        pause_until_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scoreboard.pending() != 0) begin
            scoreboard.report($sformatf("%0d pixel pairs never arrived", scoreboard.pending()));
        end

        $display("Converted %0d YUYV words, including corner and clamping cases; %0d checked.",
                 scoreboard.accepted, scoreboard.checked);
        $display("Input was held back on %0d offered cycles under output stalls and a hold-off.",
                 stalled_offers);
        if (scoreboard.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
